// File: src/swps_pkg.sv
// shared types and constants of the salience weighted pitch smoother
// payload structs, divider request and response, fixed field widths
// no dependencies
package swps_pkg;

    localparam int OP_W    = 1;
    localparam int BIN_W   = 10;
    localparam int SAL_W   = 16;
    localparam int PITCH_W = 18;
    localparam int HOP_W   = 5;
    localparam int PROD_W  = BIN_W + SAL_W;
    localparam int WSUM_W  = 40;
    localparam int FSUM_W  = 24;
    localparam int FRAME_W = 7;

    // shared divider: quotient is always a pitch, divisor is a salience sum or a count
    localparam int NUM_W = 48;
    localparam int DEN_W = FSUM_W;
    localparam int QUO_W = PITCH_W;

    localparam logic [HOP_W-1:0]   HOP_RESET = HOP_W'(2);
    localparam logic [FRAME_W-1:0] FRAME_SAT = {FRAME_W{1'b1}};

    localparam int DEF_MAX_HOP        = 31;
    localparam int DEF_WINDOW_DEPTH   = 64;
    localparam int DEF_MAX_CANDIDATES = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CAND  = 1'b0,
        OP_EMPTY = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BIN_W-1:0] bin_index;
        logic [SAL_W-1:0] salience;
        logic             voiced;
        logic             frame_last;
        logic             melody_last;
    } cand_t;

    typedef struct packed {
        logic [PITCH_W-1:0] smoothed_pitch;
        logic               melody_end;
        logic               run_last;
    } pitch_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

// File: src/swps_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// the caller guarantees the quotient fits in QUO_W bits; depends on swps_pkg
module swps_div
    import swps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] shf_reg, shf_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] trial;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, shf_reg[QUO_W-1]};
        fits  = trial >= {1'b0, den_reg};

        rem_next  = rem_reg;
        shf_next  = shf_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            // upper part of the dividend is already below the divisor
            rem_next = req.num[QUO_W+DEN_W-1:QUO_W];
            shf_next = req.num[QUO_W-1:0];
            den_next = req.den;
            cnt_next = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            shf_next  = {shf_reg[QUO_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = cnt_reg == CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = shf_reg;

endmodule

// File: src/salience_weighted_pitch_smoother.sv
// salience weighted pitch smoother: per-frame weighted mean pitch and centered average
// top level; depends on swps_pkg and swps_div
//
// usage
//   cand_valid/cand_stall/cand_data carry one pitch candidate or one empty-frame marker
//   per request. pitch_valid/pitch_stall/pitch_data carry one smoothed frame pitch per
//   request. cfg_we/cfg_data write the window half-width at any idle moment.
// operation
//   one request is worked on at a time. a request that does not end a frame passes
//   through S_ACC and back to idle. a frame end passes S_FEND, the mean division in
//   S_FDIV when the salience sum is nonzero, and S_STORE; then each result it releases
//   reads k window entries one per cycle from the ring memory, where k = 2h+1 at most,
//   followed by the shared divider. a result appears h frames after its own frame, and
//   the melody end request releases every pending frame.
// reset
//   half-width returns to 2, the frame sums and the counters clear; the ring memory is not
//   cleared, no entry is read before it has been written.
// stall
//   results wait in the output register while pitch_stall is high; the next request
//   is still taken and worked on until a new result needs that register.
module salience_weighted_pitch_smoother
    import swps_pkg::*;
#(
    parameter int MAX_HOP        = DEF_MAX_HOP,
    parameter int WINDOW_DEPTH   = DEF_WINDOW_DEPTH,
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cand_valid,
    output logic             cand_stall,
    input  cand_t            cand_data,
    output logic             pitch_valid,
    input  logic             pitch_stall,
    output pitch_t           pitch_data,
    input  logic             cfg_we,
    input  logic [HOP_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int MOD_W  = CNT_W + 1;
    localparam int CAND_W = $clog2(MAX_CANDIDATES + 1);
    localparam int SUM_W  = PITCH_W + IDX_W;
    localparam int HOP_LIMIT = (MAX_HOP < (WINDOW_DEPTH - 1) / 2) ?
                               MAX_HOP : (WINDOW_DEPTH - 1) / 2;
    localparam logic [MOD_W-1:0] DEPTH_M  = MOD_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_FEND,
        S_FDIV,
        S_STORE,
        S_CHECK,
        S_SUM,
        S_ADIV,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    cand_t               item_reg, item_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [FSUM_W-1:0]   fsum_reg, fsum_next;
    logic [CAND_W-1:0]   ccnt_reg, ccnt_next;
    logic [PITCH_W-1:0]  held_reg, held_next;
    logic [IDX_W-1:0]    fs_reg, fs_next;
    logic [CNT_W-1:0]    pend_reg, pend_next;
    logic [FRAME_W-1:0]  nof_reg, nof_next;
    logic [IDX_W-1:0]    ridx_reg, ridx_next;
    logic [CNT_W-1:0]    iss_reg, iss_next;
    logic                rpend_reg, rpend_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                pv_reg, pv_next;
    pitch_t              pd_reg, pd_next;

    logic [PITCH_W-1:0] ring [WINDOW_DEPTH];
    logic [PITCH_W-1:0] rdata_reg;
    logic               rd_en;
    logic               wr_en;

    div_req_t dreq;
    div_rsp_t drsp;

    int               hop_int;
    int               h_int;
    int               nof_int;
    logic [CNT_W-1:0] h_eff;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] pm1;
    logic [CNT_W-1:0] rext;
    logic [MOD_W-1:0] fs_m;
    logic [MOD_W-1:0] pend_m;
    logic [MOD_W-1:0] left_m;
    logic [MOD_W-1:0] pos_m;
    logic [MOD_W-1:0] start_m;
    logic             take;
    logic             fend;
    logic             emit_more;
    logic             sum_done;
    logic [NUM_W-1:0] wext;

    swps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // window geometry of the oldest pending frame
    always_comb
    begin
        hop_int = int'(hop_reg);
        h_int   = (hop_int > HOP_LIMIT) ? HOP_LIMIT : hop_int;
        nof_int = int'(nof_reg);
        h_eff   = CNT_W'(h_int);
        left    = CNT_W'((nof_int < h_int) ? nof_int : h_int);
        pm1     = pend_reg - CNT_W'(1);
        rext    = (item_reg.melody_last && pm1 < h_eff) ? pm1 : h_eff;
        fs_m    = MOD_W'(fs_reg);
        pend_m  = MOD_W'(pend_reg);
        left_m  = MOD_W'(left);
        pos_m   = (fs_m >= pend_m) ? fs_m - pend_m : fs_m + DEPTH_M - pend_m;
        start_m = (pos_m >= left_m) ? pos_m - left_m : pos_m + DEPTH_M - left_m;
        emit_more = item_reg.melody_last ? (pend_reg != '0) : (pend_reg > h_eff);
    end

    assign take     = (item_reg.op == OP_CAND) && item_reg.voiced
                      && (ccnt_reg < CAND_W'(MAX_CANDIDATES));
    assign fend     = (item_reg.op == OP_EMPTY) || item_reg.frame_last || item_reg.melody_last;
    assign sum_done = (iss_reg == '0) && !rpend_reg;
    assign wext     = NUM_W'(wsum_reg);
    assign rd_en    = (state_reg == S_SUM) && (iss_reg != '0);
    assign wr_en    = state_reg == S_STORE;

    // one divider serves the frame mean and the window average
    always_comb
    begin
        dreq = '0;
        if (state_reg == S_FEND)
        begin
            dreq.start = fsum_reg != '0;
            // x160 as two shifts, plus half the divisor for rounding
            dreq.num   = (wext << 7) + (wext << 5) + NUM_W'(fsum_reg >> 1);
            dreq.den   = fsum_reg;
        end
        else if (state_reg == S_SUM)
        begin
            dreq.start = sum_done;
            dreq.num   = NUM_W'(sum_reg) + NUM_W'(k_reg >> 1);
            dreq.den   = DEN_W'(k_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hop_next   = cfg_we ? cfg_data : hop_reg;
        item_next  = item_reg;
        prod_next  = prod_reg;
        wsum_next  = wsum_reg;
        fsum_next  = fsum_reg;
        ccnt_next  = ccnt_reg;
        held_next  = held_reg;
        fs_next    = fs_reg;
        pend_next  = pend_reg;
        nof_next   = nof_reg;
        ridx_next  = ridx_reg;
        iss_next   = iss_reg;
        rpend_next = rd_en;
        sum_next   = sum_reg;
        k_next     = k_reg;
        pv_next    = (pv_reg && !pitch_stall) ? 1'b0 : pv_reg;
        pd_next    = pd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cand_valid)
                begin
                    item_next  = cand_data;
                    prod_next  = cand_data.bin_index * cand_data.salience;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (take)
                begin
                    wsum_next = wsum_reg + WSUM_W'(prod_reg);
                    fsum_next = fsum_reg + FSUM_W'(item_reg.salience);
                    ccnt_next = ccnt_reg + CAND_W'(1);
                end
                state_next = fend ? S_FEND : S_IDLE;
            end
            S_FEND:
            begin
                wsum_next  = '0;
                fsum_next  = '0;
                ccnt_next  = '0;
                state_next = (fsum_reg != '0) ? S_FDIV : S_STORE;
            end
            S_FDIV:
            begin
                if (drsp.done)
                begin
                    // a zero mean keeps the previous pitch
                    if (drsp.quo != '0)
                    begin
                        held_next = drsp.quo;
                    end
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                fs_next    = (fs_reg == LAST_IDX) ? '0 : fs_reg + IDX_W'(1);
                pend_next  = pend_reg + CNT_W'(1);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (emit_more)
                begin
                    ridx_next  = start_m[IDX_W-1:0];
                    k_next     = left + rext + CNT_W'(1);
                    iss_next   = left + rext + CNT_W'(1);
                    sum_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    if (item_reg.melody_last)
                    begin
                        held_next = '0;
                        fs_next   = '0;
                        pend_next = '0;
                        nof_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                if (rd_en)
                begin
                    ridx_next = (ridx_reg == LAST_IDX) ? '0 : ridx_reg + IDX_W'(1);
                    iss_next  = iss_reg - CNT_W'(1);
                end
                if (rpend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rdata_reg);
                end
                if (sum_done)
                begin
                    state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                if (drsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!pv_reg || !pitch_stall)
                begin
                    pv_next                = 1'b1;
                    pd_next.smoothed_pitch = drsp.quo;
                    pd_next.melody_end     = item_reg.melody_last && (pend_reg == CNT_W'(1));
                    pd_next.run_last       = item_reg.melody_last ? (pend_reg == CNT_W'(1))
                                                                  : (pm1 <= h_eff);
                    pend_next              = pm1;
                    nof_next               = (nof_reg == FRAME_SAT) ? nof_reg
                                                                    : nof_reg + FRAME_W'(1);
                    state_next             = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hop_reg   <= HOP_RESET;
            wsum_reg  <= '0;
            fsum_reg  <= '0;
            ccnt_reg  <= '0;
            held_reg  <= '0;
            fs_reg    <= '0;
            pend_reg  <= '0;
            nof_reg   <= '0;
            iss_reg   <= '0;
            rpend_reg <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hop_reg   <= hop_next;
            wsum_reg  <= wsum_next;
            fsum_reg  <= fsum_next;
            ccnt_reg  <= ccnt_next;
            held_reg  <= held_next;
            fs_reg    <= fs_next;
            pend_reg  <= pend_next;
            nof_reg   <= nof_next;
            iss_reg   <= iss_next;
            rpend_reg <= rpend_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prod_reg <= prod_next;
        ridx_reg <= ridx_next;
        sum_reg  <= sum_next;
        k_reg    <= k_next;
        pd_reg   <= pd_next;
    end

    // ring of held pitches, the write of a frame always lands before its window is read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring[fs_reg] <= held_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= ring[ridx_reg];
        end
    end

    assign cand_stall  = state_reg != S_IDLE;
    assign pitch_valid = pv_reg;
    assign pitch_data  = pd_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench of salience_weighted_pitch_smoother: a directed table, then random melodies
// every result is checked against a behavioral predictor or a fixed expected value; depends on swps_pkg and the rtl
module tb_top;
    import swps_pkg::*;

    localparam int RING_DEPTH    = DEF_WINDOW_DEPTH;
    localparam int ITEMS_TOTAL   = 430;
    localparam int MAX_WAIT      = 13;
    localparam int SETTLE_CYCLES = 64;
    // every request releasing 32 results, each stalled to the limit
    localparam int CYCLE_LIMIT   =
        3 * (ITEMS_TOTAL + 200) * (MAX_WAIT + 1 + 40 + 32 * (86 + MAX_WAIT + 1));

    typedef struct {
        bit                 is_cfg;
        logic [HOP_W-1:0]   hop;
        cand_t              item;
        int                 reps;
        bit                 typed;
        logic [PITCH_W-1:0] pitch;
        bit                 mend;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cand_valid = 1'b0;
    logic             cand_stall;
    cand_t            cand_data = '0;
    logic             pitch_valid;
    logic             pitch_stall = 1'b0;
    pitch_t           pitch_data;
    logic             cfg_we = 1'b0;
    logic [HOP_W-1:0] cfg_data = '0;

    // predictor state
    logic [HOP_W-1:0] hop_reg = HOP_RESET;
    longint unsigned  bin_acc = 0;
    int unsigned      sal_acc = 0;
    int unsigned      n_cand = 0;
    int unsigned      held = 0;
    int unsigned      ring [RING_DEPTH];
    int unsigned      ring_wr = 0;
    int unsigned      pend = 0;
    int unsigned      out_frame = 0;

    pitch_t   exp_q [$];
    pitch_t   want;
    dir_row_t dir_tab [$];
    int       errors = 0;
    int       reqs_sent = 0;
    int       recv_wait = 0;
    int       cycles = 0;
    bit       no_idle = 1'b0;

    salience_weighted_pitch_smoother dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cand_valid  (cand_valid),
        .cand_stall  (cand_stall),
        .cand_data   (cand_data),
        .pitch_valid (pitch_valid),
        .pitch_stall (pitch_stall),
        .pitch_data  (pitch_data),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // average of the oldest pending frame with right extent r
    function automatic logic [PITCH_W-1:0] smooth_oldest(int unsigned h, int unsigned r);
        int unsigned pos, left, first, k, j, acc;
        pos   = (ring_wr + RING_DEPTH - pend) % RING_DEPTH;
        left  = (out_frame < h) ? out_frame : h;
        first = (pos + RING_DEPTH - left) % RING_DEPTH;
        k     = left + r + 1;
        acc   = 0;
        for (j = 0; j < k; j++)
            acc += ring[(first + j) % RING_DEPTH];
        pend--;
        if (out_frame < 127)
            out_frame++;
        return PITCH_W'((acc + k / 2) / k);
    endfunction

    task automatic predict_pitch(input cand_t c, output int n);
        int unsigned h, mean, r;
        pitch_t      res;
        mean = 0;
        n    = 0;
        if (c.op == OP_CAND && c.voiced && n_cand < DEF_MAX_CANDIDATES)
        begin
            bin_acc += longint'(c.bin_index) * longint'(c.salience);
            sal_acc += c.salience;
            n_cand++;
        end
        if (!(c.op == OP_EMPTY || c.frame_last || c.melody_last))
            return;
        if (sal_acc != 0)
            mean = int'((160 * bin_acc + sal_acc / 2) / sal_acc);
        if (mean != 0)
            held = mean;
        bin_acc = 0;
        sal_acc = 0;
        n_cand  = 0;
        ring[ring_wr] = held;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        pend++;
        h = hop_reg;
        if (h > DEF_MAX_HOP)
            h = DEF_MAX_HOP;
        if (h > (RING_DEPTH - 1) / 2)
            h = (RING_DEPTH - 1) / 2;
        res.run_last = 1'b0;
        if (c.melody_last)
        begin
            while (pend > 0)
            begin
                r = (pend - 1 > h) ? h : pend - 1;
                res.smoothed_pitch = smooth_oldest(h, r);
                res.melody_end     = (pend == 0);
                exp_q.push_back(res);
                n++;
            end
            held      = 0;
            ring_wr   = 0;
            pend      = 0;
            out_frame = 0;
        end
        else
        begin
            while (pend > h)
            begin
                res.smoothed_pitch = smooth_oldest(h, h);
                res.melody_end     = 1'b0;
                exp_q.push_back(res);
                n++;
            end
        end
        if (n > 0)
        begin
            res = exp_q.pop_back();
            res.run_last = 1'b1;
            exp_q.push_back(res);
        end
    endtask

    task automatic send_request(input cand_t c, output int n);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            cand_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cand_valid <= 1'b1;
        cand_data  <= c;
        @(posedge clk);
        while (cand_stall)
            @(posedge clk);
        reqs_sent++;
        predict_pitch(c, n);
    endtask

    // sender holds off until every result is in and the block has settled
    task automatic drain_results();
        cand_valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hop(input logic [HOP_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        hop_reg   = v;
    endtask

    function automatic cand_t mk(op_t op, int bin, int sal, bit v, bit fl, bit ml);
        cand_t c;
        c.op          = op;
        c.bin_index   = BIN_W'(bin);
        c.salience    = SAL_W'(sal);
        c.voiced      = v;
        c.frame_last  = fl;
        c.melody_last = ml;
        return c;
    endfunction

    function automatic dir_row_t req_row(cand_t c, int reps);
        dir_row_t r;
        r        = '{default: 0};
        r.item   = c;
        r.reps   = reps;
        return r;
    endfunction

    function automatic dir_row_t typed_row(cand_t c, int pitch, bit mend);
        dir_row_t r;
        r        = req_row(c, 1);
        r.typed  = 1'b1;
        r.pitch  = PITCH_W'(pitch);
        r.mend   = mend;
        return r;
    endfunction

    function automatic dir_row_t hop_row(int hop);
        dir_row_t r;
        r        = '{default: 0};
        r.is_cfg = 1'b1;
        r.hop    = HOP_W'(hop);
        return r;
    endfunction

    function automatic cand_t noise_item();
        cand_t c;
        c = $bits(cand_t)'($urandom);
        return c;
    endfunction

    function automatic cand_t rand_candidate();
        cand_t c;
        c             = noise_item();
        c.op          = OP_CAND;
        c.voiced      = ($urandom_range(0, 7) != 0);
        c.frame_last  = 1'b0;
        c.melody_last = 1'b0;
        case ($urandom_range(0, 7))
            0: c.bin_index = '0;
            1: c.bin_index = '1;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: c.salience = '0;
            1: c.salience = '1;
            default: ;
        endcase
        return c;
    endfunction

    task automatic send_frame(input int ncand, input bit last);
        cand_t c;
        int    i, n;
        bit    closer;
        // a frame may also be closed by an empty-frame marker after its candidates
        closer = (ncand == 0) || ($urandom_range(0, 5) == 0);
        for (i = 0; i < ncand; i++)
        begin
            c = rand_candidate();
            if (i == ncand - 1 && !closer)
            begin
                c.frame_last  = last ? 1'($urandom_range(0, 1)) : 1'b1;
                c.melody_last = last;
            end
            send_request(c, n);
        end
        if (closer)
        begin
            c             = noise_item();
            c.op          = OP_EMPTY;
            c.melody_last = last;
            send_request(c, n);
        end
    endtask

    task automatic send_melody(input int nframes, input bit lean);
        int f, r, ncand, n;
        for (f = 0; f < nframes; f++)
        begin
            if (f > 0 && $urandom_range(0, 29) == 0)
            begin
                drain_results();
                write_hop(HOP_W'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 19) == 0)
                send_request(noise_item(), n);
            if (lean)
                ncand = $urandom_range(0, 1);
            else
            begin
                r = $urandom_range(0, 19);
                if (r < 2)
                    ncand = 0;
                else if (r == 2)
                    ncand = $urandom_range(17, 20);
                else
                    ncand = $urandom_range(1, 4);
            end
            send_frame(ncand, f == nframes - 1);
        end
    endtask

    always @(posedge clk)
    begin
        if (pitch_valid && !pitch_stall)
        begin
            if (exp_q.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: pitch %0d end %0b last %0b",
                             pitch_data.smoothed_pitch, pitch_data.melody_end,
                             pitch_data.run_last);
                errors++;
            end
            else
            begin
                want = exp_q.pop_front();
                if (pitch_data.smoothed_pitch !== want.smoothed_pitch ||
                    pitch_data.melody_end !== want.melody_end ||
                    pitch_data.run_last !== want.run_last)
                begin
                    if (errors < 10)
                        $display("mismatch: expected pitch %0d end %0b last %0b, got %0d %0b %0b",
                                 want.smoothed_pitch, want.melody_end, want.run_last,
                                 pitch_data.smoothed_pitch, pitch_data.melody_end,
                                 pitch_data.run_last);
                    errors++;
                end
            end
            recv_wait = draw_wait();
        end
        else if (pitch_valid && recv_wait > 0)
            recv_wait--;
        pitch_stall <= (recv_wait > 0);
    end

    initial
    begin : stimulus
        int               k, n, phase, nmel, m;
        logic [HOP_W-1:0] hv;
        pitch_t           fixed_res;

        // extremes and degenerate frames, each a one-frame melody
        dir_tab.push_back(typed_row(mk(OP_CAND, 1023, 16'hFFFF, 1, 1, 1), 163680, 1));
        dir_tab.push_back(typed_row(mk(OP_EMPTY, 0, 0, 0, 0, 1), 0, 1));
        dir_tab.push_back(typed_row(mk(OP_CAND, 0, 16'hFFFF, 1, 1, 1), 0, 1));
        dir_tab.push_back(typed_row(mk(OP_CAND, 500, 0, 1, 1, 1), 0, 1));
        dir_tab.push_back(typed_row(mk(OP_CAND, 1023, 16'hFFFF, 0, 1, 1), 0, 1));
        // multi-frame melody at the reset half-width
        dir_tab.push_back(req_row(mk(OP_CAND, 100, 16'h0100, 1, 0, 0), 1));
        dir_tab.push_back(req_row(mk(OP_CAND, 200, 16'h0300, 1, 1, 0), 1));
        dir_tab.push_back(req_row(mk(OP_EMPTY, 1023, 16'hFFFF, 1, 0, 0), 1));
        dir_tab.push_back(req_row(mk(OP_CAND, 1, 1, 1, 1, 0), 1));
        // overfull frame: the seventeenth candidate must be dropped
        dir_tab.push_back(req_row(mk(OP_CAND, 10, 16'h0100, 1, 0, 0), 16));
        dir_tab.push_back(req_row(mk(OP_CAND, 1023, 16'hFFFF, 1, 1, 0), 1));
        // melody end without frame end
        dir_tab.push_back(req_row(mk(OP_CAND, 700, 16'h8000, 1, 0, 1), 1));
        // half-width raised, then lowered while frames are pending
        dir_tab.push_back(hop_row(3));
        dir_tab.push_back(req_row(mk(OP_CAND, 333, 16'h0080, 1, 1, 0), 4));
        dir_tab.push_back(hop_row(0));
        dir_tab.push_back(req_row(mk(OP_CAND, 50, 16'h0040, 1, 1, 0), 1));
        dir_tab.push_back(req_row(mk(OP_EMPTY, 0, 0, 0, 0, 1), 1));
        // zero half-width passes held values straight through
        dir_tab.push_back(typed_row(mk(OP_CAND, 1023, 16'hFFFF, 1, 1, 0), 163680, 0));
        dir_tab.push_back(typed_row(mk(OP_EMPTY, 0, 0, 0, 0, 0), 163680, 0));
        dir_tab.push_back(typed_row(mk(OP_EMPTY, 0, 0, 0, 1, 1), 163680, 1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                drain_results();
                write_hop(dir_tab[i].hop);
            end
            else
            begin
                for (k = 0; k < dir_tab[i].reps; k++)
                begin
                    send_request(dir_tab[i].item, n);
                    if (dir_tab[i].typed)
                    begin
                        repeat (n) void'(exp_q.pop_back());
                        fixed_res.smoothed_pitch = dir_tab[i].pitch;
                        fixed_res.melody_end     = dir_tab[i].mend;
                        fixed_res.run_last       = 1'b1;
                        exp_q.push_back(fixed_res);
                    end
                end
            end
        end

        phase = 0;
        while (reqs_sent < ITEMS_TOTAL)
        begin
            drain_results();
            case (phase % 4)
                0: hv = '0;
                1: hv = '1;
                default: hv = HOP_W'($urandom_range(0, 31));
            endcase
            write_hop(hv);
            no_idle = ($urandom_range(0, 3) == 0);
            // one long melody wraps the ring and saturates the frame index
            if (phase == 2)
                send_melody(130, 1'b1);
            else
            begin
                nmel = $urandom_range(1, 3);
                for (m = 0; m < nmel; m++)
                    send_melody(($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                            : $urandom_range(1, 6), 1'b0);
            end
            phase++;
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
